FILE: hdl/piecewise_linear_flux_interpolator_defines.svh
// Assertion macros for the flux interpolator checker.
`ifndef PIECEWISE_LINEAR_FLUX_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_FLUX_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PLFI_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLFI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/plfi_pkg.sv
// Shared constants and types of the piecewise-linear flux interpolator.
package plfi_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 5;

  // Divider: 64-bit quotient, a few quotient bits per pipeline stage.
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 32;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = NUM_W / DIV_BPS;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_EVAL = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    REG_ARRIVAL = 2'd0,
    REG_COUNT   = 2'd1,
    REG_SCALE   = 2'd2,
    REG_WINDOW  = 2'd3
  } reg_e;

  // Side data that rides alongside the divider.
  typedef struct packed {
    logic [31:0] flow_lo;
    logic [31:0] flow_hi;
    logic        neg;
    logic        tzero;
    logic        kill;
  } side_t;

endpackage

FILE: hdl/piecewise_linear_flux_interpolator.sv
// Top level of the piecewise-linear flux interpolator.
//
// Usage:
//   Input items arrive on s_axis_*. tuser is the mode: a load item writes
//   one breakpoint (time, flow) into the table slot entry_index and gives
//   no result; an evaluate item gives exactly one hcl_flux on m_axis_*.
//   Registers (arrival_time, point_count, output_scale, active_window) are
//   written on the cfg_* channel, always ready; write them only while the
//   pipeline is empty.
//   Pipeline: an accepted item passes five front stages (capture, time
//   offsets, segment search and table read, differences, product), 16
//   divider stages of four quotient bits each, and four back stages
//   (combine, split 64x32 scale multiply, sum and saturate into the
//   output register) before its result shows on m_axis_tvalid.
//   Throughput: one item per cycle unless stalled; all stages registered.
//   Stall: when the output register holds an item the receiver does not
//   take, the whole pipeline holds and s_axis_tready drops; nothing is
//   lost or repeated. Load items leave the pipeline after the table write.
//   Reset: all valid bits clear, registers take their defaults. Table
//   entries are undefined until loaded.
module piecewise_linear_flux_interpolator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] entry_index, [35:4] entry_time, [67:36] entry_flow,
  // [99:68] current_time, [131:100] ignition_time, [135:132] zero
  input  logic [135:0] s_axis_tdata,
  // [0] mode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [47:0] hcl_flux
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int NP = plfi_pkg::MAX_POINTS;
  localparam int IW = plfi_pkg::IDX_W;
  localparam int CW = plfi_pkg::CNT_W;

  // Configuration registers.
  logic [31:0]   arrival_q, scale_q, window_q;
  logic [CW-1:0] count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrival_q <= 32'd5600;
      count_q   <= CW'(2);
      scale_q   <= 32'd708670;
      window_q  <= 32'd126000;
    end else if (cfg_valid_i) begin
      unique case (plfi_pkg::reg_e'(cfg_index_i))
        plfi_pkg::REG_ARRIVAL: arrival_q <= cfg_data_i;
        plfi_pkg::REG_COUNT:   count_q   <= cfg_data_i[CW-1:0];
        plfi_pkg::REG_SCALE:   scale_q   <= cfg_data_i;
        plfi_pkg::REG_WINDOW:  window_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: move everything when the output slot frees up.
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: capture the item.
  logic          s1_valid_q, s1_mode_q;
  logic [IW-1:0] s1_idx_q;
  logic [31:0]   s1_etime_q, s1_eflow_q, s1_now_q, s1_ign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (en) s1_valid_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q  <= s_axis_tuser[0];
      s1_idx_q   <= s_axis_tdata[IW-1:0];
      s1_etime_q <= s_axis_tdata[35:4];
      s1_eflow_q <= s_axis_tdata[67:36];
      s1_now_q   <= s_axis_tdata[99:68];
      s1_ign_q   <= s_axis_tdata[131:100];
    end
  end

  // Stage 2: elapsed time since arrival, early and window kills.
  logic [32:0]   s1_esub, s1_wsub;
  logic          s1_kill;
  assign s1_esub = {1'b0, s1_now_q} - {1'b0, arrival_q};
  assign s1_wsub = {1'b0, s1_now_q} - {1'b0, s1_ign_q};
  assign s1_kill = s1_esub[32] || (!s1_wsub[32] && (s1_wsub[31:0] >= window_q));

  logic          s2_valid_q, s2_mode_q, s2_kill_q;
  logic [IW-1:0] s2_idx_q;
  logic [31:0]   s2_e_q, s2_etime_q, s2_eflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (en) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_mode_q  <= s1_mode_q;
      s2_kill_q  <= s1_kill;
      s2_idx_q   <= s1_idx_q;
      s2_e_q     <= s1_esub[31:0];
      s2_etime_q <= s1_etime_q;
      s2_eflow_q <= s1_eflow_q;
    end
  end

  // Stage 2 -> 3: table write for loads, segment search and pair read.
  // Breakpoint times also live in flops so every slot compares at once.
  logic [31:0] time_q [NP];
  logic [63:0] mem_lo [NP];
  logic [63:0] mem_hi [NP];
  logic        s2_load;
  assign s2_load = s2_valid_q && (plfi_pkg::mode_e'(s2_mode_q) == plfi_pkg::MODE_LOAD);

  always_ff @(posedge clk_i) begin
    if (en && s2_load) time_q[s2_idx_q] <= s2_etime_q;
  end

  logic [NP-1:0] lt;
  logic [CW-1:0] n_eff;
  logic [IW-1:0] last, k, k_hi;

  always_comb begin
    for (int j = 0; j < NP; j++) lt[j] = time_q[j] < s2_e_q;
  end

  always_comb begin
    priority if (count_q < CW'(2)) n_eff = CW'(2);
    else if (count_q > CW'(NP))    n_eff = CW'(NP);
    else                           n_eff = count_q;
  end

  assign last = IW'(n_eff - CW'(1));

  // Smallest k with k+1 the last point or time[k+1] >= e.
  always_comb begin
    k = last - IW'(1);
    for (int j = NP - 2; j >= 0; j--) begin
      if (((CW'(j) + CW'(2)) < n_eff) && !lt[j+1]) k = IW'(j);
    end
  end

  assign k_hi = k + IW'(1);

  logic [63:0] rd_lo_q, rd_hi_q;

  always_ff @(posedge clk_i) begin
    if (en && s2_load) begin
      mem_lo[s2_idx_q] <= {s2_etime_q, s2_eflow_q};
      mem_hi[s2_idx_q] <= {s2_etime_q, s2_eflow_q};
    end
    if (en) begin
      rd_lo_q <= mem_lo[k];
      rd_hi_q <= mem_hi[k_hi];
    end
  end

  logic        s3_valid_q, s3_kill_q;
  logic [31:0] s3_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_valid_q <= 1'b0;
    else if (en) s3_valid_q <= s2_valid_q &&
                               (plfi_pkg::mode_e'(s2_mode_q) == plfi_pkg::MODE_EVAL);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_kill_q <= s2_kill_q || lt[last];
      s3_e_q    <= s2_e_q;
    end
  end

  // Stage 4: signed differences as magnitude and sign.
  logic [31:0] t0, f0, t1, f1;
  assign t0 = rd_lo_q[63:32];
  assign f0 = rd_lo_q[31:0];
  assign t1 = rd_hi_q[63:32];
  assign f1 = rd_hi_q[31:0];

  logic        s4_valid_q;
  logic [31:0] s4_dmag_q, s4_fmag_q, s4_tmag_q;
  plfi_pkg::side_t s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_valid_q <= 1'b0;
    else if (en) s4_valid_q <= s3_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_tmag_q         <= (t1 >= t0) ? t1 - t0 : t0 - t1;
      s4_dmag_q         <= (s3_e_q >= t0) ? s3_e_q - t0 : t0 - s3_e_q;
      s4_fmag_q         <= (f1 >= f0) ? f1 - f0 : f0 - f1;
      s4_side_q.flow_lo <= f0;
      s4_side_q.flow_hi <= f1;
      s4_side_q.neg     <= (t1 < t0) ^ (s3_e_q < t0) ^ (f1 < f0);
      s4_side_q.tzero   <= (t1 == t0);
      s4_side_q.kill    <= s3_kill_q;
    end
  end

  // Stage 5: distance times flow step.
  logic        s5_valid_q;
  logic [63:0] s5_prod_q;
  logic [31:0] s5_tmag_q;
  plfi_pkg::side_t s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_valid_q <= 1'b0;
    else if (en) s5_valid_q <= s4_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_prod_q <= 64'(s4_dmag_q) * 64'(s4_fmag_q);
      s5_tmag_q <= s4_tmag_q;
      s5_side_q <= s4_side_q;
    end
  end

  // Divide by the segment length.
  logic            dv_valid;
  logic [63:0]     dv_quot;
  plfi_pkg::side_t dv_side;

  plfi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_valid_q),
    .num_i   (s5_prod_q),
    .den_i   (s5_tmag_q),
    .side_i  (s5_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Stage 6: apply the step to the lower flow; clamp to zero or all ones.
  logic [64:0] up_sum;
  logic [63:0] flux_d;
  assign up_sum = {1'b0, dv_quot} + {33'd0, dv_side.flow_lo};

  always_comb begin
    priority if (dv_side.kill)  flux_d = '0;
    else if (dv_side.tzero)     flux_d = {32'd0, dv_side.flow_hi};
    else if (dv_side.neg) begin
      if (dv_quot >= {32'd0, dv_side.flow_lo}) flux_d = '0;
      else flux_d = {32'd0, dv_side.flow_lo} - dv_quot;
    end else begin
      flux_d = up_sum[64] ? '1 : up_sum[63:0];
    end
  end

  logic        s6_valid_q;
  logic [63:0] s6_flux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_valid_q <= 1'b0;
    else if (en) s6_valid_q <= dv_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) s6_flux_q <= flux_d;
  end

  // Stages 7 and 8: scale multiply split into two 32x32 halves.
  logic        s7_valid_q, s8_valid_q;
  logic [63:0] s7_pl_q, s8_pl_q, s8_ph_q;
  logic [31:0] s7_fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
    end else if (en) begin
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_pl_q <= 64'(s6_flux_q[31:0]) * 64'(scale_q);
      s7_fh_q <= s6_flux_q[63:32];
      s8_ph_q <= 64'(s7_fh_q) * 64'(scale_q);
      s8_pl_q <= s7_pl_q;
    end
  end

  // Output: combine halves, drop 16 fraction bits, saturate at 48 bits.
  logic [64:0] hi_sum;
  logic [47:0] flux_out;
  assign hi_sum   = {1'b0, s8_ph_q} + {33'd0, s8_pl_q[63:32]};
  assign flux_out = (hi_sum[64:32] != '0) ? '1 : {hi_sum[31:0], s8_pl_q[31:16]};

  logic [47:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= s8_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_data_q <= flux_out;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: hdl/plfi_div.sv
// Pipelined restoring divider, 64-bit by 32-bit, with side data.
module plfi_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [plfi_pkg::NUM_W-1:0]    num_i,
  input  logic [plfi_pkg::DEN_W-1:0]    den_i,
  input  plfi_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [plfi_pkg::NUM_W-1:0]    quot_o,
  output plfi_pkg::side_t               side_o
);

  localparam int NW = plfi_pkg::NUM_W;
  localparam int DW = plfi_pkg::DEN_W;
  localparam int NS = plfi_pkg::DIV_STAGES;

  logic [DW-1:0]   rem_q  [NS];
  logic [NW-1:0]   num_q  [NS];
  logic [DW-1:0]   den_q  [NS];
  plfi_pkg::side_t side_q [NS];
  logic [NS-1:0]   vld_q;

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic [DW-1:0]   rem_in;
    logic [NW-1:0]   num_in;
    logic [DW-1:0]   den_in;
    plfi_pkg::side_t side_in;
    logic            vld_in;
    logic [DW-1:0]   rem_c;
    logic [NW-1:0]   num_c;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    always_comb begin
      logic [DW:0] rs;
      rem_c = rem_in;
      num_c = num_in;
      for (int b = 0; b < plfi_pkg::DIV_BPS; b++) begin
        rs    = {rem_c, num_c[NW-1]};
        num_c = {num_c[NW-2:0], 1'b0};
        if (rs >= {1'b0, den_in}) begin
          rs       = rs - {1'b0, den_in};
          num_c[0] = 1'b1;
        end
        rem_c = rs[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_c;
        num_q[s]  <= num_c;
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = num_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

FILE: hdl/plfi_checker.sv
// Port-level checker for the flux interpolator, bound to the top level.
`include "piecewise_linear_flux_interpolator_defines.svh"

module plfi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  `PLFI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `PLFI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  `PLFI_ASSERT_NOW(a_stall_back, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")
  `PLFI_ASSERT_NOW(a_free_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input refused with free output")

endmodule

bind piecewise_linear_flux_interpolator plfi_checker u_plfi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/sv/plfi_scoreboard.sv
// Checker for the flux interpolator: table mirror, flux prediction and result compare.
`timescale 1ns / 100ps
module plfi_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output int           flux_pending_o,
  output int           flux_checked_o,
  output int           fail_count_o
);

  logic [31:0] bp_time [plfi_pkg::MAX_POINTS];
  logic [31:0] bp_flow [plfi_pkg::MAX_POINTS];
  logic [31:0] arrival_q, scale_q, window_q;
  logic [4:0]  count_q;
  logic [47:0] flux_expect_q [$];

  // Exact signed interpolation, then the Q16.16 scale with saturation.
  function automatic logic [47:0] predict_flux(logic [31:0] now, logic [31:0] ign);
    logic [31:0]         e;
    logic signed [33:0]  age;
    int                  n, k;
    logic signed [127:0] t0, t1, f0, f1, ev, dt, q, flux, prod;
    if (now < arrival_q) return '0;
    e = now - arrival_q;
    n = (count_q < 2) ? 2 : (count_q > plfi_pkg::MAX_POINTS) ? plfi_pkg::MAX_POINTS : count_q;
    if (e > bp_time[n-1]) return '0;
    age = $signed({2'b0, now}) - $signed({2'b0, ign});
    if (age >= $signed({2'b0, window_q})) return '0;
    k = 0;
    while (k + 2 < n && bp_time[k+1] < e) k++;
    t0 = $signed({96'b0, bp_time[k]});
    t1 = $signed({96'b0, bp_time[k+1]});
    f0 = $signed({96'b0, bp_flow[k]});
    f1 = $signed({96'b0, bp_flow[k+1]});
    ev = $signed({96'b0, e});
    dt = t1 - t0;
    if (dt == 0) begin
      flux = f1;
    end else begin
      q    = ((ev - t0) * (f1 - f0)) / dt;
      flux = f0 + q;
    end
    if (flux <= 0) return '0;
    if (flux > $signed({64'b0, 64'hFFFF_FFFF_FFFF_FFFF}))
      flux = $signed({64'b0, 64'hFFFF_FFFF_FFFF_FFFF});
    prod = flux * $signed({96'b0, scale_q});
    if (prod > $signed({64'b0, 64'hFFFF_FFFF_FFFF_FFFF})) return 48'hFFFF_FFFF_FFFF;
    return prod[63:16];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [47:0] want;
    if (!rst_ni) begin
      arrival_q = 32'd5600;
      count_q   = 5'd2;
      scale_q   = 32'd708670;
      window_q  = 32'd126000;
      flux_expect_q.delete();
      fail_count_o   = 0;
      flux_checked_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (plfi_pkg::reg_e'(cfg_index_i))
          plfi_pkg::REG_ARRIVAL: arrival_q = cfg_data_i;
          plfi_pkg::REG_COUNT:   count_q   = cfg_data_i[4:0];
          plfi_pkg::REG_SCALE:   scale_q   = cfg_data_i;
          plfi_pkg::REG_WINDOW:  window_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (plfi_pkg::mode_e'(s_axis_tuser[0]) == plfi_pkg::MODE_LOAD) begin
          bp_time[s_axis_tdata[3:0]] = s_axis_tdata[35:4];
          bp_flow[s_axis_tdata[3:0]] = s_axis_tdata[67:36];
        end else begin
          flux_expect_q.push_back(predict_flux(s_axis_tdata[99:68], s_axis_tdata[131:100]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (flux_expect_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("ERROR: unexpected flux %h with nothing pending", m_axis_tdata);
        end else begin
          want = flux_expect_q.pop_front();
          flux_checked_o++;
          if (want !== m_axis_tdata) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: hcl_flux expected %h got %h", want, m_axis_tdata);
          end
        end
      end
    end
    flux_pending_o = flux_expect_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: stimulus, flow control phases and verdict for the flux interpolator.
`timescale 1ns / 100ps
module tb;

  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 238;
  localparam int DRAIN      = 40;     // longer than the pipeline
  localparam int CYCLE_CAP  = 600000;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         cfg_valid_i, cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  int flux_pending, flux_checked, fail_count;
  int send_idle_pct, recv_stall_pct;
  int cycles;
  bit hold_req;
  int loads_sent, evals_sent;

  // Shadow of the table and settings, used only to steer stimulus.
  logic [31:0] shadow_time [plfi_pkg::MAX_POINTS];
  logic [31:0] cur_arrival, cur_window;
  int          cur_count;

  piecewise_linear_flux_interpolator dut (.*);

  plfi_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .flux_pending_o(flux_pending), .flux_checked_o(flux_checked),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort on a hang.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request to back up the pipe.
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item; hold it until accepted. Valid stays up into the next item.
  task automatic send_item(plfi_pkg::mode_e mode, logic [3:0] idx, logic [31:0] t,
                           logic [31:0] f, logic [31:0] now, logic [31:0] ign);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'b0, ign, now, f, t, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (mode == plfi_pkg::MODE_LOAD) begin
      shadow_time[idx] = t;
      loads_sent++;
    end else begin
      evals_sent++;
    end
  endtask

  task automatic load_entry(int idx, logic [31:0] t, logic [31:0] f);
    send_item(plfi_pkg::MODE_LOAD, idx[3:0], t, f, $urandom, $urandom);
  endtask

  task automatic eval_at(logic [31:0] now, logic [31:0] ign);
    send_item(plfi_pkg::MODE_EVAL, 4'($urandom), $urandom, $urandom, now, ign);
  endtask

  task automatic write_reg(plfi_pkg::reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      plfi_pkg::REG_ARRIVAL: cur_arrival = data;
      plfi_pkg::REG_COUNT:   cur_count = (data[4:0] < 2) ? 2 :
                                         (data[4:0] > plfi_pkg::MAX_POINTS) ?
                                         plfi_pkg::MAX_POINTS : data[4:0];
      plfi_pkg::REG_WINDOW:  cur_window = data;
      default: ;
    endcase
  endtask

  // Drop valid, wait for every result, then let loads clear the pipe.
  task automatic drain_pipe();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (flux_pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Fill the whole table; mostly ascending times with repeats and wide jumps, or random.
  task automatic fill_table(bit ascending);
    logic [31:0] t;
    t = $urandom_range(0, 5000);
    for (int i = 0; i < plfi_pkg::MAX_POINTS; i++) begin
      load_entry(i, ascending ? t : $urandom,
                 ($urandom_range(3) == 0) ? $urandom_range(0, 32'h0010_0000) : $urandom);
      t = t + (($urandom_range(5) == 0) ? 32'd0 :
               ($urandom_range(7) == 0) ? $urandom_range(0, 32'h0FFF_FFFF)
                                        : $urandom_range(1, 20000));
    end
  endtask

  // Evaluation time: mostly inside the table span, some before arrival or anywhere.
  function automatic logic [31:0] pick_now();
    logic [31:0] last;
    int          r;
    last = shadow_time[cur_count-1];
    r    = $urandom_range(99);
    if (r < 70) return cur_arrival + $urandom_range(0, last + last / 8 + 2);
    if (r < 80) return cur_arrival - $urandom_range(1, 100);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_ign(logic [31:0] now);
    logic [32:0] span;
    if ($urandom_range(99) < 75) begin
      span = {1'b0, cur_window} + cur_window / 8 + 1;
      return now - $urandom_range(0, (span > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0]);
    end
    return $urandom;
  endfunction

  initial begin
    logic [31:0] arr_set [PHASES];
    logic [31:0] cnt_set [PHASES];
    logic [31:0] scl_set [PHASES];
    logic [31:0] win_set [PHASES];
    logic [31:0] now;

    arr_set = '{32'd5600, 32'd0, 32'hFFFF_F000, $urandom, 32'd1000, 32'hFFFF_FFFF};
    cnt_set = '{32'd16, 32'd0, 32'd31, 32'd9, 32'd1, 32'd2};
    scl_set = '{32'd708670, 32'hFFFF_FFFF, 32'd0, $urandom, 32'd1, 32'hFFFF_FFFF};
    win_set = '{32'd126000, 32'hFFFF_FFFF, 32'd0, $urandom, 32'h0100_0000, 32'd5};

    cycles = 0; hold_req = 0; loads_sent = 0; evals_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    cur_arrival = 32'd5600; cur_count = 2; cur_window = 32'd126000;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: known table, then corner evaluations at reset settings and at full scale.
    for (int i = 0; i < plfi_pkg::MAX_POINTS; i++)
      load_entry(i, 32'd1000 * (i + 1), 32'h0001_0000 * (16 - i));
    load_entry(1, 32'd1000, 32'h0000_8000);            // equal times in segment 0
    eval_at(32'd5599, 32'd0);                          // before arrival
    eval_at(32'd5600, 32'd5600);                       // elapsed zero, below first point
    eval_at(32'd5600 + 32'd1000, 32'd6000);            // on the repeated time
    eval_at(32'd5600 + 32'd1001, 32'd6000);            // past last point with two points
    eval_at(32'd6000, 32'd6000 - 32'd126000);          // ignition wraps to after now: no window kill
    eval_at(32'd6000, 32'hFFFF_FFFF);                  // ignition after now
    load_entry(0, 32'd900, 32'h0000_0010);             // steep rise, evaluated at the upper point
    load_entry(1, 32'd1000, 32'hFFFF_FFFF);
    eval_at(32'd5600 + 32'd1000, 32'd6600);
    load_entry(0, 32'd900, 32'hFFFF_FFFF);
    load_entry(1, 32'd1000, 32'h0000_0000);
    eval_at(32'd5600 + 32'd0, 32'd5600);               // before the first point on a descent: large positive flux
    drain_pipe();
    write_reg(plfi_pkg::REG_SCALE, 32'hFFFF_FFFF);
    load_entry(0, 32'd0, 32'hFFFF_FFFF);
    load_entry(1, 32'd1, 32'hFFFF_FFFF);
    eval_at(32'd5600, 32'd5600);                       // near the top, no saturation
    load_entry(0, 32'd0, 32'd0);
    load_entry(1, 32'd1, 32'hFFFF_FFFF);
    eval_at(32'd5600 + 32'd0, 32'd5600);               // flux zero from the first point
    drain_pipe();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(plfi_pkg::REG_ARRIVAL, arr_set[p]);
      write_reg(plfi_pkg::REG_COUNT,   cnt_set[p]);
      write_reg(plfi_pkg::REG_SCALE,   scl_set[p]);
      write_reg(plfi_pkg::REG_WINDOW,  win_set[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      fill_table(p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Back up the pipe once with the sender running flat out.
        if (p == 0 && i == 40) hold_req = 1'b1;
        if ($urandom_range(99) < 20) begin
          load_entry($urandom_range(0, plfi_pkg::MAX_POINTS - 1),
                     shadow_time[$urandom_range(0, plfi_pkg::MAX_POINTS - 1)]
                       + $urandom_range(0, 3000)
                       ^ (($urandom_range(9) == 0) ? $urandom : 32'd0),
                     $urandom);
        end else begin
          now = pick_now();
          eval_at(now, pick_ign(now));
        end
      end
      drain_pipe();
    end

    $display("Covered %0d table loads and %0d flux evaluations (%0d results checked)",
             loads_sent, evals_sent, flux_checked);
    $display("over %0d register settings and four flow-control mixes, one long stall",
             PHASES + 1);
    if (fail_count == 0 && flux_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
